/* sv/sfd_pkg.sv */
`default_nettype none

package sfd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 9;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] SYNC_RESET = 8'h55;
  localparam logic [7:0] ACCEL_RESET = 8'h51;
  localparam logic SHORT_RESET = 1'b1;

  typedef enum logic [1:0] {
    CFG_SYNC_VALUE  = 2'd0,
    CFG_ACCEL_CODE  = 2'd1,
    CFG_ALLOW_SHORT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_GOOD   = 2'd0,
    STATUS_SHORT  = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         frame_type;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_z;
    logic signed [15:0] word_temp;
    logic               is_accel;
    logic [1:0]         frame_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] accel_type_code;
    logic       allow_short;
  } cfg_t;

  // body[k] holds frame byte k+1
  typedef struct packed {
    logic [PAYLOAD_BYTES-1:0][7:0] body;
    status_e                       status;
  } frame_rec_t;

endpackage

`default_nettype wire

/* sv/sensor_frame_deframer.sv */
// Channel | Direction | Handshake                  | Beat
// in      | input     | in_valid_i / in_ready_o    | sfd_pkg::in_item_t
// out     | output    | out_valid_o / out_ready_i  | sfd_pkg::out_item_t
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One input byte per cycle while in_ready_o is high; a frame result is written to the
// result queue at the edge that takes its last byte, then popped into the output
// register that drives out_valid_o once that register is free.
// The two-entry result queue is the only stall source: in_ready_o drops
// only when it is full. cfg_ready_o is always high.
// Reset clears the parser position, checksum, queue and output valid.
`default_nettype none

module sensor_frame_deframer #(
  parameter int unsigned FRAME_LENGTH = 11
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sfd_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sfd_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);

  sfd_pkg::cfg_t       cfg_q;
  sfd_pkg::frame_rec_t front_rec, queue_rec;
  logic                push, full, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value      <= sfd_pkg::SYNC_RESET;
      cfg_q.accel_type_code <= sfd_pkg::ACCEL_RESET;
      cfg_q.allow_short     <= sfd_pkg::SHORT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sfd_pkg::cfg_idx_e'(cfg_index_i))
        sfd_pkg::CFG_SYNC_VALUE:  cfg_q.sync_value      <= cfg_data_i;
        sfd_pkg::CFG_ACCEL_CODE:  cfg_q.accel_type_code <= cfg_data_i;
        sfd_pkg::CFG_ALLOW_SHORT: cfg_q.allow_short     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sfd_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (front_rec)
  );

  sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rec_o   (queue_rec)
  );

  sfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .rec_i        (queue_rec),
    .pop_o        (pop),
    .accel_code_i (cfg_q.accel_type_code),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

/* sv/sfd_front.sv */
`default_nettype none

module sfd_front #(
  parameter int unsigned FRAME_LENGTH = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sfd_pkg::in_item_t in_data_i,
  input  wire sfd_pkg::cfg_t     cfg_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output sfd_pkg::frame_rec_t    rec_o
);

  localparam int unsigned FILL_W = $clog2(FRAME_LENGTH);
  localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(FRAME_LENGTH - 1);

  logic [FILL_W-1:0] fill_q, fill_d, fill_eff;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        byte0_q;
  logic [7:0]        body_q [sfd_pkg::PAYLOAD_BYTES];
  logic              accept, is_sync, in_frame, at_last, store_byte0;
  logic [7:0]        b;
  sfd_pkg::status_e  status;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;
  assign is_sync    = (b == cfg_i.sync_value);
  assign fill_eff   = (in_data_i.packet_start && is_sync) ? '0 : fill_q;
  assign in_frame   = (fill_eff != '0) || is_sync;
  assign at_last    = (fill_eff == LAST_POS);
  assign push_o     = accept && in_frame && at_last;

  always_comb begin
    priority if (byte0_q != cfg_i.sync_value) begin
      status = sfd_pkg::STATUS_REJECT;
    end else if (b == sum_q) begin
      status = sfd_pkg::STATUS_GOOD;
    end else if (is_sync && cfg_i.allow_short) begin
      status = sfd_pkg::STATUS_SHORT;
    end else begin
      status = sfd_pkg::STATUS_REJECT;
    end
  end

  always_comb begin
    fill_d      = fill_q;
    sum_d       = sum_q;
    store_byte0 = 1'b0;
    if (accept) begin
      if (!in_frame) begin
        fill_d = '0;
      end else if (at_last) begin
        if (status == sfd_pkg::STATUS_SHORT) begin
          fill_d      = FILL_W'(1);
          sum_d       = b;
          store_byte0 = 1'b1;
        end else begin
          fill_d = '0;
          sum_d  = '0;
        end
      end else begin
        fill_d = fill_eff + FILL_W'(1);
        sum_d  = ((fill_eff == '0) ? 8'h00 : sum_q) + b;
        if (fill_eff == '0) begin
          store_byte0 = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_byte0) begin
      byte0_q <= b;
    end
    for (int k = 0; k < int'(sfd_pkg::PAYLOAD_BYTES); k++) begin
      if (accept && in_frame && !at_last && (k + 1 < int'(FRAME_LENGTH) - 1) &&
          (int'(fill_eff) == k + 1)) begin
        body_q[k] <= b;
      end
    end
  end

  always_comb begin
    rec_o.status = status;
    for (int k = 0; k < int'(sfd_pkg::PAYLOAD_BYTES); k++) begin
      rec_o.body[k] = (k + 1 < int'(FRAME_LENGTH) - 1) ? body_q[k] : 8'h00;
    end
  end

endmodule

`default_nettype wire

/* sv/sfd_queue.sv */
`default_nettype none

module sfd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sfd_pkg::frame_rec_t rec_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output sfd_pkg::frame_rec_t      rec_o
);

  localparam int unsigned PTR_W = $clog2(sfd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sfd_pkg::QUEUE_DEPTH + 1);

  sfd_pkg::frame_rec_t mem_q [sfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_q, rd_q;
  logic [CNT_W-1:0]    count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(sfd_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/sfd_back.sv */
`default_nettype none

module sfd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire sfd_pkg::frame_rec_t rec_i,
  output logic                     pop_o,
  input  wire logic [7:0]          accel_code_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sfd_pkg::out_item_t       out_data_o
);

  logic                out_valid_q;
  sfd_pkg::out_item_t  out_q, fmt;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    fmt = '0;
    fmt.frame_status = rec_i.status;
    if (rec_i.status != sfd_pkg::STATUS_REJECT) begin
      fmt.frame_type = rec_i.body[0];
      fmt.word_x     = {rec_i.body[2], rec_i.body[1]};
      fmt.word_y     = {rec_i.body[4], rec_i.body[3]};
      fmt.word_z     = {rec_i.body[6], rec_i.body[5]};
      fmt.word_temp  = {rec_i.body[8], rec_i.body[7]};
      fmt.is_accel   = (rec_i.body[0] == accel_code_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the beat while the sink stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= fmt;
    end
  end

endmodule

`default_nettype wire

/* sv/sfd_checker.sv */
`default_nettype none

module sfd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire sfd_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire sfd_pkg::out_item_t out_data_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [1:0]         cfg_index_i,
  input wire logic [7:0]         cfg_data_i
);

  logic unused;
  assign unused = ^{in_valid_i, in_data_i, cfg_valid_i, cfg_index_i, cfg_data_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_status != 2'd3)
    else $error("undefined frame status");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_status == sfd_pkg::STATUS_REJECT |->
      out_data_o.frame_type == 8'h00 && out_data_o.word_x == 16'sd0 &&
      out_data_o.word_y == 16'sd0 && out_data_o.word_z == 16'sd0 &&
      out_data_o.word_temp == 16'sd0 && !out_data_o.is_accel)
    else $error("rejected frame carries payload");

  a_stall_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire

/* dv/tb_sensor_frame_deframer.sv */
module tb_sensor_frame_deframer;

  localparam int CLK_PERIOD = 4;
  localparam int FRAME_LEN = 11;
  localparam int DIR_ROWS = 35;
  localparam int ITEM_TARGET = 900;
  localparam int RAND_PHASES = 8;

  typedef struct packed {
    sfd_pkg::in_item_t  beat;
    logic               typed;
    sfd_pkg::out_item_t want;
  } dir_row_t;

  localparam sfd_pkg::out_item_t GOOD_EXTREMES = '{frame_type: 8'h51, word_x: 16'sh8000,
                                                   word_y: 16'sh7FFF, word_z: -16'sd1,
                                                   word_temp: 16'sd0, is_accel: 1'b1,
                                                   frame_status: sfd_pkg::STATUS_GOOD};
  localparam sfd_pkg::out_item_t REJECTED = '{frame_status: sfd_pkg::STATUS_REJECT,
                                              default: '0};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  sfd_pkg::in_item_t  in_beat = '0;
  logic               beat_typed = 1'b0;
  sfd_pkg::out_item_t beat_want = '0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  logic               in_ready_o;
  logic               out_valid_o;
  sfd_pkg::out_item_t out_data_o;
  logic               cfg_ready_o;

  // shadow of the parser
  logic [7:0] sync_val = sfd_pkg::SYNC_RESET;
  logic [7:0] accel_code = sfd_pkg::ACCEL_RESET;
  logic       short_ok = sfd_pkg::SHORT_RESET;
  logic [7:0] frame_bytes [FRAME_LEN];
  int         fill_pos = 0;
  logic [7:0] run_sum = '0;

  sfd_pkg::out_item_t exp_frames [$];
  int        errors = 0;
  int        beats_in = 0;
  int        frames_checked = 0;
  int        items_sent = 0;
  int        settings_used = 1;
  int        idle_in_pct = 0;
  int        stall_out_pct = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h55, 1'b1}, 1'b0, '0},
    '{'{8'h55, 1'b0}, 1'b0, '0},
    '{'{8'h55, 1'b1}, 1'b0, '0},
    '{'{8'h51, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h7F, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'hA2, 1'b0}, 1'b1, GOOD_EXTREMES},
    '{'{8'h55, 1'b1}, 1'b0, '0},
    '{'{8'hAA, 1'b0}, 1'b0, '0},
    '{'{8'h12, 1'b0}, 1'b0, '0},
    '{'{8'h34, 1'b0}, 1'b0, '0},
    '{'{8'h56, 1'b0}, 1'b0, '0},
    '{'{8'h78, 1'b0}, 1'b0, '0},
    '{'{8'h9A, 1'b0}, 1'b0, '0},
    '{'{8'hBC, 1'b0}, 1'b0, '0},
    '{'{8'hDE, 1'b0}, 1'b0, '0},
    '{'{8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'h55, 1'b0}, 1'b0, '0},
    '{'{8'h51, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b1, REJECTED}
  };

  sensor_frame_deframer #(
    .FRAME_LENGTH(FRAME_LEN)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  initial begin
    foreach (frame_bytes[k]) frame_bytes[k] = '0;
  end

  function automatic logic [7:0] body_byte(input int k);
    if (k + 1 >= FRAME_LEN) return 8'h00;
    return frame_bytes[k];
  endfunction

  function automatic logic deframe_byte(input sfd_pkg::in_item_t beat,
                                        output sfd_pkg::out_item_t res);
    logic [7:0]       b;
    logic [7:0]       last;
    sfd_pkg::status_e st;
    b = beat.data_byte;
    res = '0;
    if (beat.packet_start && b == sync_val) fill_pos = 0;
    if (fill_pos == 0 && b != sync_val) return 1'b0;
    if (fill_pos >= FRAME_LEN) fill_pos = 0;
    if (fill_pos == 0) run_sum = '0;
    frame_bytes[fill_pos] = b;
    if (fill_pos + 1 < FRAME_LEN) run_sum = run_sum + b;
    fill_pos++;
    if (fill_pos < FRAME_LEN) return 1'b0;

    last = frame_bytes[FRAME_LEN-1];
    if (frame_bytes[0] != sync_val) st = sfd_pkg::STATUS_REJECT;
    else if (last == run_sum) st = sfd_pkg::STATUS_GOOD;
    else if (last == sync_val && short_ok) st = sfd_pkg::STATUS_SHORT;
    else st = sfd_pkg::STATUS_REJECT;

    if (st != sfd_pkg::STATUS_REJECT) begin
      res.frame_type = body_byte(1);
      res.word_x     = {body_byte(3), body_byte(2)};
      res.word_y     = {body_byte(5), body_byte(4)};
      res.word_z     = {body_byte(7), body_byte(6)};
      res.word_temp  = {body_byte(9), body_byte(8)};
      res.is_accel   = (body_byte(1) == accel_code);
    end
    res.frame_status = st;

    // with short frames allowed, a sync byte in the checksum slot that misses the sum opens the next frame
    if (st == sfd_pkg::STATUS_SHORT) begin
      frame_bytes[0] = last;
      run_sum = last;
      fill_pos = 1;
    end else begin
      fill_pos = 0;
      run_sum = '0;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    sfd_pkg::out_item_t res;
    sfd_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        beats_in++;
        if (deframe_byte(in_beat, res))
          exp_frames.push_back(beat_typed ? beat_want : res);
      end
      if (out_valid_o && out_ready) begin
        if (exp_frames.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame result: expected none, got %h", $time,
                   out_data_o);
        end else begin
          want = exp_frames.pop_front();
          frames_checked++;
          check_field("frame_type", 16'(want.frame_type), 16'(out_data_o.frame_type));
          check_field("word_x", want.word_x, out_data_o.word_x);
          check_field("word_y", want.word_y, out_data_o.word_y);
          check_field("word_z", want.word_z, out_data_o.word_z);
          check_field("word_temp", want.word_temp, out_data_o.word_temp);
          check_field("is_accel", 16'(want.is_accel), 16'(out_data_o.is_accel));
          check_field("frame_status", 16'(want.frame_status),
                      16'(out_data_o.frame_status));
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_out_pct);

  task automatic send_byte(input sfd_pkg::in_item_t beat, input logic typed,
                           input sfd_pkg::out_item_t want);
    if (idle_in_pct != 0 && $urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in_pct);
    end
    in_valid   <= 1'b1;
    in_beat    <= beat;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_frames.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input sfd_pkg::cfg_idx_e idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      sfd_pkg::CFG_SYNC_VALUE:  sync_val = val;
      sfd_pkg::CFG_ACCEL_CODE:  accel_code = val;
      sfd_pkg::CFG_ALLOW_SHORT: short_ok = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_burst();
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] sum;
    int         kind;
    int         cut;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(12, 1)) begin
        send_byte('{data_byte: rand_byte(), packet_start: 1'($urandom_range(1))},
                  1'b0, '0);
        items_sent++;
      end
      return;
    end
    fr[0] = sync_val;
    fr[1] = $urandom_range(1) ? accel_code : rand_byte();
    sum = fr[0] + fr[1];
    for (int k = 2; k < FRAME_LEN - 1; k++) begin
      fr[k] = rand_byte();
      sum = sum + fr[k];
    end
    if (kind < 25) fr[FRAME_LEN-1] = sync_val;
    else if (kind < 37) fr[FRAME_LEN-1] = sum ^ 8'(1 << $urandom_range(7));
    else fr[FRAME_LEN-1] = sum;
    cut = (kind >= 90) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
    for (int k = 0; k < cut; k++) begin
      send_byte('{data_byte: fr[k],
                  packet_start: (k == 0) ? 1'($urandom_range(1))
                                         : ($urandom_range(15) == 0)},
                1'b0, '0);
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_byte(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
    items_sent = DIR_ROWS;

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(sfd_pkg::CFG_SYNC_VALUE, 8'h00);
          write_reg(sfd_pkg::CFG_ACCEL_CODE, 8'hFF);
          write_reg(sfd_pkg::CFG_ALLOW_SHORT, {7'($urandom), 1'b0});
        end
        1: begin
          write_reg(sfd_pkg::CFG_SYNC_VALUE, 8'hFF);
          write_reg(sfd_pkg::CFG_ACCEL_CODE, 8'h00);
          write_reg(sfd_pkg::CFG_ALLOW_SHORT, {7'($urandom), 1'b1});
        end
        default: begin
          write_reg(sfd_pkg::CFG_SYNC_VALUE, rand_byte());
          write_reg(sfd_pkg::CFG_ACCEL_CODE, rand_byte());
          write_reg(sfd_pkg::CFG_ALLOW_SHORT, 8'($urandom));
        end
      endcase
      settings_used++;
      case (p % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 68; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 68; end
        default: begin idle_in_pct = 7; stall_out_pct = 7; end
      endcase
      target = DIR_ROWS + (ITEM_TARGET - DIR_ROWS) * (p + 1) / RAND_PHASES;
      while (items_sent < target) send_random_burst();
      // leave a frame half collected across the register change
      if ($urandom_range(1)) begin
        send_byte('{data_byte: sync_val, packet_start: 1'b1}, 1'b0, '0);
        items_sent++;
        repeat ($urandom_range(8, 1)) begin
          send_byte('{data_byte: rand_byte(), packet_start: 1'b0}, 1'b0, '0);
          items_sent++;
        end
      end
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && exp_frames.size() != 0; w++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (exp_frames.size() != 0) begin
      errors += exp_frames.size();
      $display("%0t: %0d frame results expected but never delivered", $time,
               exp_frames.size());
    end

    $display("Run covered %0d input beats and %0d checked frame results", beats_in,
             frames_checked);
    $display("under %0d register settings and four idle/stall mixes", settings_used);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(400_000 * CLK_PERIOD);
    $display("Timeout waiting for frame results");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
